/* hw/rtl/phe_pkg.sv */
// Shared constants and types for the Horner polynomial / derivative evaluator.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package phe_pkg;

  localparam int unsigned DEGREE     = 6;
  localparam int unsigned COEFF_REGS = 7;
  localparam int unsigned NSLOT      = (DEGREE + 1 > COEFF_REGS) ? DEGREE + 1 : COEFF_REGS;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned DCOEF_W    = DATA_W + 3;
  localparam int unsigned SUM_W      = PROD_W - FRAC_W + 1;
  localparam int unsigned CFG_IDX_W  = $clog2(COEFF_REGS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF0, REG_COEFF1, REG_COEFF2, REG_COEFF3, REG_COEFF4, REG_COEFF5, REG_COEFF6,
    REG_SPARE
  } cfg_reg_e;

  typedef logic signed [DATA_W-1:0]  q_t;
  typedef logic signed [DCOEF_W-1:0] dq_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic ovf;
    q_t   val;
  } sat_t;

  typedef struct packed {
    q_t   x;
    q_t   pv;
    q_t   sv;
    logic ovf;
  } acc_t;

  typedef struct packed {
    q_t    x;
    prod_t pp;
    prod_t sp;
    q_t    sv;
    logic  ovf;
  } prd_t;

endpackage

/* hw/rtl/phe_in_if.sv */
// Input channel: one evaluation point per transaction.
// Depends on phe_pkg.
`timescale 1ns / 1ps

interface phe_in_if import phe_pkg::*; ();
  logic valid;
  logic ready;
  q_t   point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

/* hw/rtl/phe_out_if.sv */
// Result channel: polynomial value, slope and overflow flag per transaction.
// Depends on phe_pkg.
`timescale 1ns / 1ps

interface phe_out_if import phe_pkg::*; ();
  logic valid;
  logic ready;
  q_t   poly_value;
  q_t   slope_value;
  logic overflow;

  modport source (output valid, output poly_value, output slope_value, output overflow,
                  input ready);
  modport sink   (input valid, input poly_value, input slope_value, input overflow,
                  output ready);
endinterface

/* hw/rtl/polynomial_horner_eval_with_derivative_unit.sv */
// Pipelined Horner evaluator of p(x) and p'(x) in signed Q16.16.
// Depends on phe_pkg, phe_in_if and phe_out_if.
//
//   channel   dir  payload                                 handshake
//   point_i   in   point                                   valid/ready
//   result_o  out  poly_value, slope_value, overflow       valid/ready
//   cfg       in   cfg_idx_i, cfg_data_i                   cfg_we_i, no wait
//
// One transaction per cycle while the result channel accepts; one multiply
// stage and one shift/add/saturate stage per Horner step plus a setup stage.
// Reset clears all coefficients to zero and empties the pipeline.
// Each stage holds under backpressure; empty stages keep filling, so input
// ready drops only when every stage is occupied.
`timescale 1ns / 1ps

module polynomial_horner_eval_with_derivative_unit import phe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  phe_in_if.sink               point_i,
  phe_out_if.source            result_o
);

  function automatic sat_t step_sat(prod_t p, dq_t c);
    sum_t                   s;
    logic [SUM_W-DATA_W:0]  hi;
    sat_t                   r;
    s  = sum_t'(p >>> FRAC_W) + sum_t'(c);
    hi = s[SUM_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      r.ovf = 1'b0;
      r.val = s[DATA_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = s[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // coefficients and derived slope coefficients d[j] = (j+1)*c[j+1]
  q_t   coeff_q [NSLOT];
  dq_t  d_q     [DEGREE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) coeff_q[i] <= '0;
      for (int j = 0; j < DEGREE; j++) d_q[j] <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (i < COEFF_REGS && cfg_idx_i == CFG_IDX_W'(i)) coeff_q[i] <= cfg_data_i;
      end
      for (int j = 0; j < DEGREE; j++) begin
        if (j + 1 < COEFF_REGS && cfg_idx_i == CFG_IDX_W'(j + 1)) begin
          d_q[j] <= dq_t'(signed'(cfg_data_i)) * dq_t'(j + 1);
        end
      end
    end
  end

  // pipeline
  acc_t               acc_q [DEGREE+1];
  acc_t               acc_d [DEGREE+1];
  prd_t               prd_q [1:DEGREE];
  prd_t               prd_d [1:DEGREE];
  logic [DEGREE:0]    vld_a_q;
  logic [DEGREE:1]    vld_m_q;
  logic [DEGREE:0]    en_a;
  logic [DEGREE:1]    en_m;

  always_comb begin
    en_a[DEGREE] = !vld_a_q[DEGREE] || result_o.ready;
    for (int k = DEGREE; k >= 1; k--) begin
      en_m[k]   = !vld_m_q[k] || en_a[k];
      en_a[k-1] = !vld_a_q[k-1] || en_m[k];
    end
  end

  assign point_i.ready = en_a[0];

  sat_t init_s;
  assign init_s = step_sat('0, d_q[DEGREE-1]);

  always_comb begin
    acc_d[0].x   = point_i.point;
    acc_d[0].pv  = coeff_q[DEGREE];
    acc_d[0].sv  = init_s.val;
    acc_d[0].ovf = init_s.ovf;
  end

  for (genvar k = 1; k <= DEGREE; k++) begin : g_step
    sat_t p_s;
    sat_t s_s;

    always_comb begin
      prd_d[k].x   = acc_q[k-1].x;
      prd_d[k].pp  = prod_t'(acc_q[k-1].pv) * prod_t'(acc_q[k-1].x);
      prd_d[k].sp  = prod_t'(acc_q[k-1].sv) * prod_t'(acc_q[k-1].x);
      prd_d[k].sv  = acc_q[k-1].sv;
      prd_d[k].ovf = acc_q[k-1].ovf;
    end

    assign p_s = step_sat(prd_q[k].pp, dq_t'(coeff_q[DEGREE-k]));

    if (k < DEGREE) begin : g_slope
      assign s_s = step_sat(prd_q[k].sp, d_q[DEGREE-1-k]);
    end else begin : g_hold
      assign s_s = '{ovf: 1'b0, val: prd_q[k].sv};
    end

    always_comb begin
      acc_d[k].x   = prd_q[k].x;
      acc_d[k].pv  = p_s.val;
      acc_d[k].sv  = s_s.val;
      acc_d[k].ovf = prd_q[k].ovf | p_s.ovf | s_s.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_m_q <= '0;
    end else begin
      if (en_a[0]) vld_a_q[0] <= point_i.valid;
      for (int k = 1; k <= DEGREE; k++) begin
        if (en_m[k]) vld_m_q[k] <= vld_a_q[k-1];
        if (en_a[k]) vld_a_q[k] <= vld_m_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a[0] && point_i.valid) acc_q[0] <= acc_d[0];
    for (int k = 1; k <= DEGREE; k++) begin
      if (en_m[k] && vld_a_q[k-1]) prd_q[k] <= prd_d[k];
      if (en_a[k] && vld_m_q[k])   acc_q[k] <= acc_d[k];
    end
  end

  assign result_o.valid       = vld_a_q[DEGREE];
  assign result_o.poly_value  = acc_q[DEGREE].pv;
  assign result_o.slope_value = acc_q[DEGREE].sv;
  assign result_o.overflow    = acc_q[DEGREE].ovf;

`ifndef NO_ASSERTIONS
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_i.ready |-> ((&vld_a_q) && (&vld_m_q)))
    else $error("input blocked while pipeline has a bubble");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && point_i.ready |=> vld_a_q[0])
    else $error("accepted transaction missing from setup stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q[DEGREE] && !result_o.ready |=> vld_a_q[DEGREE] && $stable(acc_q[DEGREE]))
    else $error("stalled result changed");

  a_dcoef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_COEFF1 |=> d_q[0] == dq_t'(coeff_q[1]))
    else $error("derived slope coefficient mismatch");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Horner polynomial and slope evaluator.
// Depends on phe_pkg, phe_in_if, phe_out_if and the top-level RTL; compares
// every result with a directed value or a Q16.16 predictor, with random idling on both channels but in the last phase.
`timescale 1ns / 1ps

module testbench import phe_pkg::*; ();

  localparam q_t Q_ONE       = 32'sh0001_0000;
  localparam q_t Q_MAX       = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN       = 32'sh8000_0000;
  localparam int LATENCY     = 2 * DEGREE + 1;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 158;

  typedef struct packed {
    q_t   poly;
    q_t   slope;
    logic ovf;
  } outcome_t;

  typedef q_t coeff_set_t [COEFF_REGS];

  typedef struct {
    int       coeff_set;
    q_t       point;
    bit       typed;
    outcome_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;

  phe_in_if  pt_if ();
  phe_out_if res_if ();

  polynomial_horner_eval_with_derivative_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .point_i    (pt_if),
    .result_o   (res_if)
  );

  coeff_set_t coeff_shadow;
  outcome_t   pending_q [$];
  bit         idle_on = 1'b1;
  int         mism_cnt = 0;
  int         n_points = 0;
  int         n_results = 0;
  int         n_ovf = 0;
  int         n_sets = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one Horner step: floor(acc*x / 2^16) + c, saturated to 32 bits
  function automatic longint horner_step_sat(longint acc, q_t x, longint c, inout bit ovf);
    longint s;
    s = ((acc * longint'(x)) >>> FRAC_W) + c;
    if (s > longint'(Q_MAX)) begin
      ovf = 1'b1;
      return longint'(Q_MAX);
    end
    if (s < longint'(Q_MIN)) begin
      ovf = 1'b1;
      return longint'(Q_MIN);
    end
    return s;
  endfunction

  function automatic outcome_t horner_eval(q_t x);
    longint   pv;
    longint   sv;
    longint   c;
    bit       ovf;
    outcome_t r;
    pv  = 0;
    sv  = 0;
    ovf = 1'b0;
    for (int i = DEGREE; i >= 0; i--) begin
      c  = (i < COEFF_REGS) ? longint'(coeff_shadow[i]) : 0;
      pv = horner_step_sat(pv, x, c, ovf);
    end
    // derivative coefficients stay exact, only the sums saturate
    for (int i = DEGREE - 1; i >= 0; i--) begin
      c  = (i + 1 < COEFF_REGS) ? longint'(i + 1) * longint'(coeff_shadow[i + 1]) : 0;
      sv = horner_step_sat(sv, x, c, ovf);
    end
    r.poly  = q_t'(pv);
    r.slope = q_t'(sv);
    r.ovf   = ovf;
    return r;
  endfunction

  function automatic dir_row_t row(int cset, q_t x, bit typed, q_t p, q_t s, logic o);
    dir_row_t r;
    r.coeff_set  = cset;
    r.point      = x;
    r.typed      = typed;
    r.want.poly  = p;
    r.want.slope = s;
    r.want.ovf   = o;
    return r;
  endfunction

  function automatic q_t rand_special();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      default: return q_t'($urandom);
    endcase
  endfunction

  function automatic q_t rand_coeff(int style);
    case (style)
      0:       return q_t'($urandom);
      1:       return q_t'(int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      2:       return rand_special();
      default: return q_t'(int'($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
    endcase
  endfunction

  function automatic q_t rand_point(int style);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (style == 1 && pick < 6)
      return q_t'(int'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
    case (pick)
      0, 1, 2: return q_t'(int'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      3, 4, 5: return q_t'($urandom);
      6:       return q_t'(int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      7:       return q_t'(int'($urandom_range(0, 511)) - 256);
      default: return rand_special();
    endcase
  endfunction

  task automatic load_coeffs(input coeff_set_t cs);
    foreach (cs[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(REG_COEFF0 + i);
      cfg_data <= cs[i];
      @(posedge clk);
    end
    // unmapped index, must not disturb any coefficient
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SPARE;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we       <= 1'b0;
    coeff_shadow = cs;
    n_sets++;
  endtask

  task automatic send_point(input q_t x, input bit use_typed, input outcome_t typed_val);
    outcome_t exp_val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pt_if.valid <= 1'b1;
    pt_if.point <= x;
    do @(negedge clk); while (pt_if.ready !== 1'b1);
    @(posedge clk);
    exp_val   = use_typed ? typed_val : horner_eval(x);
    pending_q = {pending_q, exp_val};
    n_points++;
  endtask

  task automatic drain_results();
    pt_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : result_ready_drive
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0)
        res_if.ready <= 1'b0;
      else
        res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(negedge clk) begin : result_check
    outcome_t want;
    outcome_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.poly  = res_if.poly_value;
      got.slope = res_if.slope_value;
      got.ovf   = res_if.overflow;
      n_results++;
      if (got.ovf === 1'b1)
        n_ovf++;
      if (pending_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("%0t: result with no pending transaction: poly=%h slope=%h ovf=%b",
                   $realtime, got.poly, got.slope, got.ovf);
      end else begin
        want = pending_q.pop_front();
        if (got.poly !== want.poly || got.slope !== want.slope || got.ovf !== want.ovf) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("%0t: mismatch exp poly=%h slope=%h ovf=%b got poly=%h slope=%h ovf=%b",
                     $realtime, want.poly, want.slope, want.ovf,
                     got.poly, got.slope, got.ovf);
        end
      end
    end
  end

  initial begin : stimulus
    coeff_set_t dir_sets [8];
    dir_row_t   dir_tab [$];
    coeff_set_t cs;
    int         cur_set;
    int         style;
    int         trim;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_COEFF0;
    cfg_data     = '0;
    pt_if.valid  = 1'b0;
    pt_if.point  = '0;
    coeff_shadow = '{default: '0};

    foreach (dir_sets[k])
      dir_sets[k] = '{default: '0};
    dir_sets[1][0] = Q_MAX;
    dir_sets[2][0] = Q_MIN;
    dir_sets[3][1] = Q_ONE;
    dir_sets[4]    = '{default: Q_MAX};
    dir_sets[5]    = '{default: Q_MIN};
    dir_sets[6][6] = Q_ONE;
    dir_sets[7]    = '{32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, -32'sh0000_8000,
                       32'sh0000_1000, 32'sh0000_0800, -32'sh0000_0100};

    // coefficients straight out of reset
    dir_tab = {dir_tab, row(0, '0,     1'b1, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(0, Q_MAX,  1'b1, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(0, Q_MIN,  1'b1, '0, '0, 1'b0)};
    // constant polynomials
    dir_tab = {dir_tab, row(1, Q_MAX,  1'b1, Q_MAX, '0, 1'b0)};
    dir_tab = {dir_tab, row(1, Q_MIN,  1'b1, Q_MAX, '0, 1'b0)};
    dir_tab = {dir_tab, row(2, Q_MAX,  1'b1, Q_MIN, '0, 1'b0)};
    dir_tab = {dir_tab, row(2, -Q_ONE, 1'b1, Q_MIN, '0, 1'b0)};
    // p(x) = x, upper coefficients zero
    dir_tab = {dir_tab, row(3, Q_MAX,  1'b1, Q_MAX, Q_ONE, 1'b0)};
    dir_tab = {dir_tab, row(3, Q_MIN,  1'b1, Q_MIN, Q_ONE, 1'b0)};
    dir_tab = {dir_tab, row(3, -32'sd1, 1'b1, -32'sd1, Q_ONE, 1'b0)};
    // inner derivative step saturates, final value back in range
    dir_tab = {dir_tab, row(4, '0,     1'b1, Q_MAX, Q_MAX, 1'b1)};
    dir_tab = {dir_tab, row(4, Q_MAX,  1'b0, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(4, Q_MIN,  1'b0, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(5, '0,     1'b1, Q_MIN, Q_MIN, 1'b1)};
    dir_tab = {dir_tab, row(5, Q_MIN,  1'b0, '0, '0, 1'b0)};
    // x^6 only
    dir_tab = {dir_tab, row(6, 32'sh0002_0000, 1'b1, 32'sh0040_0000, 32'sh00C0_0000, 1'b0)};
    dir_tab = {dir_tab, row(6, -Q_ONE, 1'b1, Q_ONE, -32'sh0006_0000, 1'b0)};
    dir_tab = {dir_tab, row(6, -32'sd1, 1'b0, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(6, 32'sh0000_8000, 1'b0, '0, '0, 1'b0)};
    // mixed signs, negative points exercise floor rounding
    dir_tab = {dir_tab, row(7, '0,     1'b1, 32'sh0001_8000, -32'sh0000_4000, 1'b0)};
    dir_tab = {dir_tab, row(7, -32'sh0001_8000, 1'b0, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(7, 32'sh0003_0000, 1'b0, '0, '0, 1'b0)};
    dir_tab = {dir_tab, row(7, Q_MIN,  1'b0, '0, '0, 1'b0)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    foreach (dir_tab[r]) begin
      if (dir_tab[r].coeff_set != cur_set) begin
        drain_results();
        load_coeffs(dir_sets[dir_tab[r].coeff_set]);
        cur_set = dir_tab[r].coeff_set;
      end
      send_point(dir_tab[r].point, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      style   = ph % 4;
      idle_on = (ph != RAND_PHASES - 1);
      foreach (cs[i])
        cs[i] = rand_coeff(style);
      if ($urandom_range(0, 1) == 1) begin
        trim = $urandom_range(0, COEFF_REGS - 1);
        foreach (cs[i])
          if (i > trim)
            cs[i] = '0;
      end
      load_coeffs(cs);
      repeat (PHASE_ITEMS) send_point(rand_point(style), 1'b0, '0);
    end

    drain_results();
    repeat (LATENCY) @(posedge clk);

    $display("Evaluated %0d points over %0d coefficient loads plus reset values.",
             n_points, n_sets);
    $display("Checked %0d results, %0d of them saturated, %0d mismatches.",
             n_results, n_ovf, mism_cnt);
    if (mism_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d transactions outstanding.", pending_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
